@@ design/assert_macros.svh @@
// Assertion macros for the files that check their own logic (the top level).
// Depends on nothing; each macro takes its clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define MAF_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// when trig holds, cons must hold in the same cycle
`define MAF_ASSERT_IMPLY(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ design/maf_pkg.sv @@
// Shared widths and types for the moving average filter.
// Depends on nothing.
package maf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 16;
    localparam int USED_W   = 3;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ design/maf_front.sv @@
// Front part: accepts samples, updates the ring, running sum and fill count.
// Depends on maf_pkg; pushes {sum, count} into the queue.
module maf_front
    import maf_pkg::*;
#(
    parameter int WINDOW = 5,
    parameter int SUM_W  = 19,
    parameter int CNT_W  = 3,
    parameter int PTR_W  = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  t_q_status                  i_q_status,
    output logic                       o_push,
    output logic signed [SUM_W-1:0]    o_sum,
    output logic        [CNT_W-1:0]    o_count
);

    logic signed [SAMPLE_W-1:0] r_store [WINDOW];
    logic        [PTR_W-1:0]    r_wp, n_wp;
    logic        [CNT_W-1:0]    r_fill, n_fill;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic signed [SUM_W-1:0]    s_ext, old_ext;
    logic                       full;
    logic                       accept;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign full    = (r_fill == CNT_W'(WINDOW));

    always_comb begin
        s_ext   = SUM_W'(i_sample);
        old_ext = full ? SUM_W'(r_store[r_wp]) : '0;
        n_sum   = r_sum - old_ext + s_ext;
        n_fill  = full ? r_fill : r_fill + CNT_W'(1);
        n_wp    = (r_wp == PTR_W'(WINDOW - 1)) ? '0 : r_wp + PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (accept) begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store[r_wp] <= i_sample;
        end
    end

    assign o_push  = accept;
    assign o_sum   = n_sum;
    assign o_count = n_fill;

endmodule

@@ design/maf_queue.sv @@
// Two-entry queue between the front and back parts.
// Depends on maf_pkg for the status struct.
module maf_queue
    import maf_pkg::*;
#(
    parameter int WIDTH = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

endmodule

@@ design/maf_back.sv @@
// Back part: bit-serial signed division of the sum by the count.
// Depends on maf_pkg; pops the queue and holds the result register.
module maf_back
    import maf_pkg::*;
#(
    parameter int SUM_W = 19,
    parameter int CNT_W = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_q_status                i_q_status,
    input  logic signed [SUM_W-1:0]  i_sum,
    input  logic        [CNT_W-1:0]  i_count,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [AVG_W-1:0]  o_average,
    output logic        [CNT_W-1:0]  o_count
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]              r_state;
    logic [STEP_W-1:0]       r_step;
    logic [SUM_W-1:0]        r_mag, n_mag;
    logic [CNT_W-1:0]        r_rem, n_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_neg;
    logic signed [AVG_W-1:0] r_avg;
    logic [CNT_W:0]          trial;
    logic                    ge;
    logic [SUM_W-1:0]        quot;
    logic                    last;

    assign o_pop = (r_state == S_IDLE) && !i_q_status.empty;
    assign last  = (r_step == STEP_W'(SUM_W - 1));

    always_comb begin
        trial = {r_rem, r_mag[SUM_W-1]};
        ge    = (trial >= {1'b0, r_cnt});
        n_rem = ge ? CNT_W'(trial - {1'b0, r_cnt}) : CNT_W'(trial);
        n_mag = {r_mag[SUM_W-2:0], ge};
        quot  = r_neg ? -n_mag : n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_RUN;
                        r_step  <= '0;
                    end
                end
                S_RUN: begin
                    r_step <= r_step + STEP_W'(1);
                    if (last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg <= i_sum[SUM_W-1];
            r_mag <= i_sum[SUM_W-1] ? -i_sum : i_sum;
            r_rem <= '0;
            r_cnt <= i_count;
        end else if (r_state == S_RUN) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
            if (last) begin
                r_avg <= quot[AVG_W-1:0];
            end
        end
    end

    assign o_valid   = (r_state == S_DONE);
    assign o_average = r_avg;
    assign o_count   = r_cnt;

endmodule

@@ design/moving_average_filter.sv @@
// Top level of the moving average filter: front, queue and back parts.
// Depends on maf_pkg, maf_front, maf_queue, maf_back and assert_macros.svh.
//
// Usage:
//   Input channel i_valid / o_ready carries one signed 16-bit i_sample per
//   item. Output channel o_valid / i_ready carries o_average, the mean of
//   the last up to WINDOW samples truncated toward zero, and
//   o_samples_used, the number of samples in that mean (low 3 bits).
//   Every accepted item gives exactly one result, in order.
//   An accepted item goes through the queue to the back part, which pops it
//   when idle. Sums have SUM_W = 16 + clog2(WINDOW) bits (19 for WINDOW 5).
//   The one-bit-a-cycle divider there holds one item at a time and takes
//   the next only after its result is taken. The front takes an item a
//   cycle until the two-entry queue fills.
//   Reset empties the window, the sum and the queue; no result is pending.
//   While the receiver stalls, the result holds, the divider waits and the
//   front keeps taking items until the queue is full, then drops o_ready.
`include "assert_macros.svh"

module moving_average_filter
    import maf_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [AVG_W-1:0]    o_average,
    output logic        [USED_W-1:0]   o_samples_used
);

    localparam int SUM_W = SAMPLE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    t_q_status               q_status;
    logic                    q_push, q_pop;
    logic signed [SUM_W-1:0] f_sum, b_sum;
    logic [CNT_W-1:0]        f_count, b_count, o_count;
    logic [31:0]             used_ext;

    maf_front #(
        .WINDOW(WINDOW), .SUM_W(SUM_W), .CNT_W(CNT_W), .PTR_W(PTR_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_sum      (f_sum),
        .o_count    (f_count)
    );

    maf_queue #(
        .WIDTH(SUM_W + CNT_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   ({f_sum, f_count}),
        .i_pop    (q_pop),
        .o_data   ({b_sum, b_count}),
        .o_status (q_status)
    );

    maf_back #(
        .SUM_W(SUM_W), .CNT_W(CNT_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_sum      (b_sum),
        .i_count    (b_count),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_average  (o_average),
        .o_count    (o_count)
    );

    assign used_ext       = 32'(o_count);
    assign o_samples_used = used_ext[USED_W-1:0];

    `MAF_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, q_push, !q_status.full)
    `MAF_ASSERT_IMPLY(a_pop_data, i_clk, i_rst_n, q_pop, !q_status.empty)
    `MAF_ASSERT_IMPLY(a_no_pop_busy, i_clk, i_rst_n, o_valid, !q_pop)
    `MAF_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, !q_status.empty,
        (b_count != '0) && (b_count <= CNT_W'(WINDOW)))
    `MAF_ASSERT_ALWAYS(a_status_excl, i_clk, i_rst_n, !(q_status.full && q_status.empty))

endmodule

@@ dv/moving_average_filter_tb.sv @@
// Self-checking testbench for moving_average_filter: directed and random samples in, averages checked.
// A clocked driver feeds items from a pending queue and a clocked monitor checks results
// against an in-bench running-sum predictor. Depends on maf_pkg and the filter RTL.
`timescale 1ns / 1ps

module moving_average_filter_tb
    import maf_pkg::*;
();

    localparam int WIN          = 5;
    localparam int LATENCY      = 16 + $clog2(WIN) + 2;
    localparam int N_RANDOM     = 1830;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 500;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        int unsigned                gap;
    } t_sample_item;

    typedef struct {
        logic signed [AVG_W-1:0] average;
        logic [USED_W-1:0]       used;
    } t_avg_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [AVG_W-1:0]    o_average;
    logic        [USED_W-1:0]   o_samples_used;

    t_sample_item pending_samples[$];
    t_avg_result  expected_avgs[$];
    t_sample_item next_item;

    logic signed [SAMPLE_W-1:0] win_ring[WIN];
    int          win_wr_idx;
    int          win_fill;
    int          win_sum;

    int unsigned send_wait;
    int unsigned rx_stall;
    int unsigned rx_hold;
    logic        hold_done;
    int unsigned results_seen;
    int unsigned error_count;
    int unsigned cycle_count;

    moving_average_filter #(
        .WINDOW(WIN)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_average      (o_average),
        .o_samples_used (o_samples_used)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void predict_average(input logic signed [SAMPLE_W-1:0] s);
        t_avg_result r;
        int          q;
        if (win_fill < WIN) begin
            win_fill++;
        end else begin
            win_sum -= win_ring[win_wr_idx];
        end
        win_ring[win_wr_idx] = s;
        win_sum += s;
        win_wr_idx = (win_wr_idx + 1 >= WIN) ? 0 : win_wr_idx + 1;
        q = win_sum / win_fill;
        r.average = q[AVG_W-1:0];
        r.used = win_fill[USED_W-1:0];
        expected_avgs.push_back(r);
    endfunction

    function automatic void check_average();
        t_avg_result exp_r;
        if (expected_avgs.size() == 0) begin
            $error("unexpected item: average=%0d samples_used=%0d", o_average, o_samples_used);
            error_count++;
            return;
        end
        exp_r = expected_avgs.pop_front();
        if (o_average !== exp_r.average) begin
            $error("average: expected %0d, actual %0d", exp_r.average, o_average);
            error_count++;
        end
        if (o_samples_used !== exp_r.used) begin
            $error("samples_used: expected %0d, actual %0d", exp_r.used, o_samples_used);
            error_count++;
        end
    endfunction

    function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] v,
                                         input int unsigned g);
        t_sample_item it;
        it.value = v;
        it.gap = g;
        pending_samples.push_back(it);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3, 4, 5: begin
                return SAMPLE_W'($urandom);
            end
            6, 7: begin
                return SAMPLE_W'($urandom_range(0, 200)) - SAMPLE_W'(100);
            end
            8: begin
                return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            default: begin
                return $urandom_range(0, 1) ? 16'sh7FFF - SAMPLE_W'($urandom_range(0, 15))
                                            : 16'sh8000 + SAMPLE_W'($urandom_range(0, 15));
            end
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_average(i_sample);
            end
            if (!i_valid || o_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    next_item = pending_samples.pop_front();
                    i_valid <= 1'b1;
                    i_sample <= next_item.value;
                    send_wait = next_item.gap;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold <= 0;
            hold_done <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            rx_hold <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_average();
                results_seen++;
                rx_stall = ((results_seen / 80) % 3 == 0) ? 0 : $urandom_range(0, 16);
            end else if (o_valid && rx_hold == 0 && rx_stall > 0) begin
                rx_stall--;
            end
            i_ready <= (rx_hold == 0 && rx_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned burst_mode;
        for (int i = 0; i < WIN; i++) begin
            win_ring[i] = '0;
        end
        win_wr_idx = 0;
        win_fill = 0;
        win_sum = 0;
        send_wait = 0;
        rx_stall = 0;
        results_seen = 0;
        error_count = 0;
        cycle_count = 0;

        // fill, wrap and overwrite with the extremes, then truncation toward zero
        for (int i = 0; i < WIN + 1; i++) begin
            queue_sample(16'sh7FFF, $urandom_range(0, 3));
        end
        for (int i = 0; i < WIN; i++) begin
            queue_sample(16'sh8000, $urandom_range(0, 3));
        end
        queue_sample(-16'sd1, 0);
        for (int i = 0; i < 4; i++) begin
            queue_sample(16'sd0, 0);
        end
        queue_sample(16'sd7, 1);
        queue_sample(-16'sd3, 0);
        queue_sample(16'sd1, 2);
        queue_sample(16'sd2, 0);
        queue_sample(16'sh5555, 0);
        queue_sample(16'shAAAA, 5);

        burst_mode = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 64 == 0) begin
                burst_mode = $urandom_range(0, 3);
            end
            queue_sample(random_sample(),
                         (burst_mode == 0 || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 16));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_samples.size() > 0 || i_valid) begin
            @(negedge i_clk);
        end
        while (expected_avgs.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (2 * LATENCY) @(negedge i_clk);
        if (expected_avgs.size() != 0) begin
            $error("%0d expected items never arrived", expected_avgs.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
